// ===== rtl/aes_round_sponge_hash_unit_assert.svh =====
// Assertion macros for the sponge hash unit.
// Depends on nothing; included by the top level.
`ifndef AES_ROUND_SPONGE_HASH_UNIT_ASSERT_SVH
`define AES_ROUND_SPONGE_HASH_UNIT_ASSERT_SVH

// Check that a condition always implies a consequence in the same cycle.
`define ARSH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Check that a condition implies a consequence in the next cycle.
`define ARSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/arsh_pkg.sv =====
// Shared types, constants and tables of the sponge hash unit.
// Depends on nothing.
package arsh_pkg;

  localparam int unsigned LaneW  = 128;
  localparam int unsigned NLanes = 6;
  localparam int unsigned WordW  = 64;

  localparam logic [2:0] MODE_RESET   = 3'd0;
  localparam logic [2:0] MODE_ABSORB  = 3'd1;
  localparam logic [2:0] MODE_TAIL    = 3'd2;
  localparam logic [2:0] MODE_FLIP    = 3'd3;
  localparam logic [2:0] MODE_SQUEEZE = 3'd4;
  localparam logic [2:0] MODE_DRAW    = 3'd5;

  localparam logic [7:0] TAIL_HDR = 8'hA0;
  localparam logic [7:0] FLIP_XOR = 8'h1F;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] data_lo;
    logic [63:0] data_hi;
    logic [3:0]  tail_length;
    logic [63:0] bound;
  } arsh_in_t;

  typedef struct packed {
    logic [63:0] out_lo;
    logic [63:0] out_hi;
  } arsh_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arsh_div_sts_t;

  localparam logic [127:0] INIT_TEXT [NLanes] = '{
    " This Is What I ",
    "   Put In The   ",
    "  State Before  ",
    "  Hashing Your  ",
    "   Stuff With   ",
    "   H A K I !!!  "
  };

  // Put the first character of a text block into byte 0.
  function automatic logic [127:0] init_lane(input int unsigned k);
    logic [127:0] t;
    logic [127:0] r;
    t = INIT_TEXT[k];
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = t[8*(15-i) +: 8];
    end
    return r;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage

// ===== rtl/arsh_aes_round.sv =====
// One AES encryption round (SubBytes, ShiftRows, MixColumns, key xor).
// Depends on arsh_pkg for the S-box table.
module arsh_aes_round (
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  output logic [127:0] out_o
);
  import arsh_pkg::*;

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  logic [7:0] t [16];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[state_i[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      out_o[8*(4*c)   +: 8] = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3]
                            ^ key_i[8*(4*c) +: 8];
      out_o[8*(4*c+1) +: 8] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3]
                            ^ key_i[8*(4*c+1) +: 8];
      out_o[8*(4*c+2) +: 8] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3]
                            ^ key_i[8*(4*c+2) +: 8];
      out_o[8*(4*c+3) +: 8] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3])
                            ^ key_i[8*(4*c+3) +: 8];
    end
  end

endmodule

// ===== rtl/arsh_mod_unit.sv =====
// Bit-serial 64-bit remainder unit, one quotient bit per cycle.
// Depends on arsh_pkg for the status struct.
module arsh_mod_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [63:0]             dividend_i,
  input  logic [63:0]             divisor_i,
  output logic [63:0]             rem_o,
  output arsh_pkg::arsh_div_sts_t sts_o
);
  import arsh_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q, div_q, rem_q;
  logic [64:0] trial;
  logic [64:0] diff;

  assign trial = {rem_q, num_q[63]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift one dividend bit in, subtract when the divisor fits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      rem_q <= diff[64] ? trial[63:0] : diff[63:0];
    end
  end

  assign rem_o      = rem_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

// ===== rtl/aes_round_sponge_hash_unit.sv =====
// Top level of the AES-round sponge hash and random generator.
// Depends on arsh_pkg, arsh_aes_round, arsh_mod_unit and the assertion header.
//
// One transaction at a time. A single AES round unit is stepped over the six
// lanes to form one permutation round. Reset state, empty tail and a draw
// with a bound of at most one finish without a permutation round; absorb,
// tail, flip and squeeze run one. A bounded draw runs the serial remainder
// unit for the threshold, then per try one permutation round plus a check
// state, then the remainder unit again for the reduction. A result waits in
// the output register while the next transaction is accepted.
module aes_round_sponge_hash_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  arsh_pkg::arsh_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output arsh_pkg::arsh_out_t out_data_o
);
  import arsh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PERM, ST_THR, ST_CHECK, ST_MOD, ST_FIN
  } state_e;

  state_e       state_q;
  logic [2:0]   step_q, mode_q;
  logic [127:0] lanes_q [NLanes];
  logic [127:0] h0_q;
  logic [63:0]  bound_q, thr_q, res_lo_q, res_hi_q;
  logic         out_valid_q;
  arsh_out_t    out_q;

  logic [127:0]  aes_s, aes_k, aes_o;
  logic          mod_start;
  logic [63:0]   mod_dividend, mod_rem;
  arsh_div_sts_t mod_sts;
  logic [127:0]  tail_src;
  logic [127:0]  tail_blk;
  logic          in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign tail_src    = {in_data_i.data_hi, in_data_i.data_lo};

  // Tail block: header byte, then the first tail_length data bytes, zeros after.
  always_comb begin
    tail_blk          = '0;
    tail_blk[7:0]     = TAIL_HDR | {4'h0, in_data_i.tail_length};
    for (int j = 1; j < 16; j++) begin
      if (j <= int'(in_data_i.tail_length)) begin
        tail_blk[8*j +: 8] = tail_src[8*(j-1) +: 8];
      end
    end
  end

  // Operand routing of the shared round unit: old lanes are read before the
  // step that overwrites them; the last step mixes lanes 2 and 4 already new.
  always_comb begin
    case (step_q)
      3'd0: begin aes_s = lanes_q[5]; aes_k = lanes_q[0]; end
      3'd1: begin aes_s = lanes_q[4]; aes_k = lanes_q[5]; end
      3'd2: begin aes_s = lanes_q[3]; aes_k = lanes_q[4]; end
      3'd3: begin aes_s = lanes_q[2]; aes_k = lanes_q[3]; end
      3'd4: begin aes_s = lanes_q[1]; aes_k = lanes_q[2]; end
      3'd5: begin aes_s = lanes_q[0]; aes_k = lanes_q[1]; end
      default: begin aes_s = h0_q; aes_k = lanes_q[2] & lanes_q[4]; end
    endcase
  end

  arsh_aes_round u_aes (
    .state_i(aes_s),
    .key_i  (aes_k),
    .out_o  (aes_o)
  );

  // Start the remainder unit for the threshold or for the final reduction.
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = 64'd0 - in_data_i.bound;
    if (in_acc && in_data_i.mode == MODE_DRAW && in_data_i.bound > 64'd1) begin
      mod_start = 1'b1;
    end else if (state_q == ST_CHECK && lanes_q[0][63:0] >= thr_q) begin
      mod_start    = 1'b1;
      mod_dividend = lanes_q[0][63:0];
    end
  end

  arsh_mod_unit u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(mod_dividend),
    .divisor_i (in_acc ? in_data_i.bound : bound_q),
    .rem_o     (mod_rem),
    .sts_o     (mod_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NLanes; k++) begin
        lanes_q[k] <= init_lane(k);
      end
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle.
      if (out_valid_q && out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            mode_q   <= in_data_i.mode;
            bound_q  <= in_data_i.bound;
            res_lo_q <= '0;
            res_hi_q <= '0;
            step_q   <= '0;
            state_q  <= ST_FIN;
            case (in_data_i.mode)
              MODE_RESET: begin
                for (int k = 0; k < NLanes; k++) begin
                  lanes_q[k] <= init_lane(k);
                end
              end
              MODE_ABSORB: begin
                lanes_q[0] <= lanes_q[0] ^ {in_data_i.data_hi, in_data_i.data_lo};
                state_q    <= ST_PERM;
              end
              MODE_TAIL: begin
                if (in_data_i.tail_length != 4'd0) begin
                  lanes_q[0] <= lanes_q[0] ^ tail_blk;
                  state_q    <= ST_PERM;
                end
              end
              MODE_FLIP: begin
                lanes_q[0][7:0] <= lanes_q[0][7:0] ^ FLIP_XOR;
                state_q         <= ST_PERM;
              end
              MODE_SQUEEZE: state_q <= ST_PERM;
              MODE_DRAW: begin
                if (in_data_i.bound > 64'd1) begin
                  state_q <= ST_THR;
                end
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end
        ST_PERM: begin
          step_q <= step_q + 3'd1;
          case (step_q)
            3'd0: h0_q       <= aes_o;
            3'd1: lanes_q[5] <= aes_o;
            3'd2: lanes_q[4] <= aes_o;
            3'd3: lanes_q[3] <= aes_o;
            3'd4: lanes_q[2] <= aes_o;
            3'd5: lanes_q[1] <= aes_o;
            default: begin
              lanes_q[0] <= aes_o;
              step_q     <= '0;
              if (mode_q == MODE_SQUEEZE) begin
                res_lo_q <= aes_o[63:0];
                res_hi_q <= aes_o[127:64];
                state_q  <= ST_FIN;
              end else if (mode_q == MODE_DRAW) begin
                state_q <= ST_CHECK;
              end else begin
                state_q <= ST_FIN;
              end
            end
          endcase
        end
        ST_THR: begin
          if (mod_sts.done) begin
            thr_q   <= mod_rem;
            state_q <= ST_PERM;
          end
        end
        ST_CHECK: begin
          // Reject a draw below the threshold and run another round.
          state_q <= mod_start ? ST_MOD : ST_PERM;
        end
        ST_MOD: begin
          if (mod_sts.done) begin
            res_lo_q <= mod_rem;
            state_q  <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Hold the result until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_q.out_lo <= res_lo_q;
            out_q.out_hi <= res_hi_q;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`include "aes_round_sponge_hash_unit_assert.svh"

  `ARSH_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_o)
  `ARSH_ASSERT_IMPL(a_mod_only_in_draw, clk_i, rst_ni, mod_sts.busy,
                    state_q == ST_THR || state_q == ST_MOD)
  `ARSH_ASSERT_IMPL(a_step_idle_zero, clk_i, rst_ni, state_q != ST_PERM, step_q == 3'd0)

endmodule
